// File: rtl/slx_pkg.sv
// ----------------------------------------------------------------------------
// slx_pkg
// Shared types, character codes and classification helpers for the lexer.
// ----------------------------------------------------------------------------
package slx_pkg;

  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned SPAN_W      = 12;
  localparam int unsigned LINE_W      = 16;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
  localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;
  localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_EQUALS = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;
  localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_RBRACK = 8'h5D;

  typedef enum logic [4:0] {
    KIND_LITERAL  = 5'd0,
    KIND_COMMENT  = 5'd1,
    KIND_DQUOTE   = 5'd2,
    KIND_SQUOTE   = 5'd3,
    KIND_COMMA    = 5'd4,
    KIND_EQUALS   = 5'd5,
    KIND_ADD      = 5'd6,
    KIND_SUB      = 5'd7,
    KIND_MUL      = 5'd8,
    KIND_DIV      = 5'd9,
    KIND_LPAREN   = 5'd10,
    KIND_RPAREN   = 5'd11,
    KIND_LBRACE   = 5'd12,
    KIND_RBRACE   = 5'd13,
    KIND_LBRACK   = 5'd14,
    KIND_RBRACK   = 5'd15,
    KIND_STMT_END = 5'd16
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [SPAN_W-1:0]  span_begin;
    logic [SPAN_W-1:0]  span_end;
    logic [LINE_W-1:0]  line;
    logic               bad;
    logic               done;
  } rec_t;

  typedef struct packed {
    logic two;
    rec_t first;
    rec_t second;
  } entry_t;

  function automatic rec_t mk_rec(input kind_e k, input logic [SPAN_W-1:0] b,
                                  input logic [SPAN_W-1:0] e,
                                  input logic [LINE_W-1:0] ln,
                                  input logic bad, input logic done);
    rec_t r;
    r.kind       = k;
    r.span_begin = b;
    r.span_end   = e;
    r.line       = ln;
    r.bad        = bad;
    r.done       = done;
    return r;
  endfunction

  function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h30 && c <= 8'h39);
  endfunction

  function automatic logic is_quote(input logic [CHAR_W-1:0] c);
    return (c == CH_DQUOTE) || (c == CH_SQUOTE);
  endfunction

  function automatic logic is_op(input logic [CHAR_W-1:0] c);
    logic r;
    case (c)
      CH_COMMA, CH_EQUALS, CH_PLUS, CH_MINUS, CH_STAR, CH_LPAREN, CH_RPAREN,
      CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic kind_e op_kind(input logic [CHAR_W-1:0] c);
    kind_e k;
    unique case (c)
      CH_COMMA:  k = KIND_COMMA;
      CH_EQUALS: k = KIND_EQUALS;
      CH_PLUS:   k = KIND_ADD;
      CH_MINUS:  k = KIND_SUB;
      CH_STAR:   k = KIND_MUL;
      CH_LPAREN: k = KIND_LPAREN;
      CH_RPAREN: k = KIND_RPAREN;
      CH_LBRACE: k = KIND_LBRACE;
      CH_RBRACE: k = KIND_RBRACE;
      CH_LBRACK: k = KIND_LBRACK;
      CH_RBRACK: k = KIND_RBRACK;
      default:   k = KIND_LITERAL;
    endcase
    return k;
  endfunction

  function automatic logic has_handler(input logic [CHAR_W-1:0] c);
    return is_alnum(c) || is_quote(c) || is_op(c) || (c == CH_SPACE) ||
           (c == CH_SLASH) || (c == CH_SEMI) || (c == CH_CR) || (c == CH_LF);
  endfunction

endpackage

// File: rtl/slx_if.sv
// ----------------------------------------------------------------------------
// slx_in_if / slx_out_if
// Valid/ready channels for source bytes and lexer results.
// ----------------------------------------------------------------------------
interface slx_in_if;
  logic                        valid;
  logic                        ready;
  logic [slx_pkg::CHAR_W-1:0]  char_code;
  logic                        end_of_input;

  modport source(output valid, output char_code, output end_of_input, input ready);
  modport sink(input valid, input char_code, input end_of_input, output ready);
endinterface

interface slx_out_if;
  logic                        valid;
  logic                        ready;
  logic [4:0]                  token_kind;
  logic [slx_pkg::SPAN_W-1:0]  span_begin;
  logic [slx_pkg::SPAN_W-1:0]  span_end;
  logic [slx_pkg::LINE_W-1:0]  line_number;
  logic                        bad_char;
  logic                        statement_done;
  logic                        last_of_run;

  modport source(output valid, output token_kind, output span_begin, output span_end,
                 output line_number, output bad_char, output statement_done,
                 output last_of_run, input ready);
  modport sink(input valid, input token_kind, input span_begin, input span_end,
               input line_number, input bad_char, input statement_done,
               input last_of_run, output ready);
endinterface

// File: rtl/statement_lexer_core.sv
// ----------------------------------------------------------------------------
// statement_lexer_core
// Streaming statement lexer: one source byte per beat in, token records out.
// ----------------------------------------------------------------------------
// Results: each byte's records are pushed into the 4-entry result queue and
//   sent from its head. Throughput: 1 byte per cycle while the queue is not
//   full; two-result bytes use separate beats and the queue absorbs bursts.
// Reset: asynchronous, active low; lexer state, line count and queue clear.
module statement_lexer_core #(
  parameter int unsigned OFFSET_BITS = 12,
  parameter int unsigned LINE_BITS   = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  slx_in_if.sink     in_i,
  slx_out_if.source  out_o
);
  import slx_pkg::*;

  logic   push, pop, full, empty;
  entry_t entry, head;

  slx_front #(
    .OFFSET_BITS (OFFSET_BITS),
    .LINE_BITS   (LINE_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (entry)
  );

  slx_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  slx_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

// File: rtl/slx_front.sv
// ----------------------------------------------------------------------------
// slx_front
// Byte classifier and lexer state; turns each beat into zero to two records.
// ----------------------------------------------------------------------------
module slx_front #(
  parameter int unsigned OFFSET_BITS = 12,
  parameter int unsigned LINE_BITS   = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  slx_in_if.sink          in_i,
  input  logic            full_i,
  output logic            push_o,
  output slx_pkg::entry_t entry_o
);
  import slx_pkg::*;

  localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};

  typedef enum logic [1:0] {
    MODE_NORMAL, MODE_LITERAL, MODE_STRING, MODE_COMMENT
  } mode_e;

  mode_e                  mode_q, mode_d;
  logic                   slash_q, slash_d;
  logic                   cr_q, cr_d;
  logic [OFFSET_BITS-1:0] start_q, start_d, stop_q, stop_d;
  logic [LINE_BITS-1:0]   line_q, line_d;

  logic [OFFSET_BITS-1:0] start_inc, stop_inc;
  logic [SPAN_W-1:0]      sb, sbi, se, sei;
  logic [LINE_W-1:0]      ln;
  logic [CHAR_W-1:0]      c;
  logic                   accept, pre_v, main_v, end_stmt, flush;
  rec_t                   pre, main;

  assign accept    = in_i.valid && in_i.ready;
  assign in_i.ready = !full_i;
  assign c         = in_i.char_code;

  assign start_inc = (start_q == OFF_MAX) ? start_q : start_q + 1'b1;
  assign stop_inc  = (stop_q == OFF_MAX) ? stop_q : stop_q + 1'b1;
  assign sb        = SPAN_W'(start_q);
  assign sbi       = SPAN_W'(start_inc);
  assign se        = SPAN_W'(stop_q);
  assign sei       = SPAN_W'(stop_inc);
  assign ln        = LINE_W'(line_q);

  assign flush = (mode_q == MODE_LITERAL) && !is_alnum(c) && !((c == CH_LF) && cr_q);

  always_comb begin
    mode_d   = mode_q;
    slash_d  = slash_q;
    cr_d     = 1'b0;
    start_d  = start_q;
    stop_d   = stop_q;
    line_d   = line_q;
    end_stmt = 1'b0;
    pre_v    = 1'b0;
    main_v   = 1'b0;
    pre      = mk_rec(KIND_LITERAL, sb, se, ln, 1'b0, 1'b0);
    main     = mk_rec(KIND_LITERAL, se, se, ln, 1'b0, 1'b0);

    if (in_i.end_of_input) begin
      pre_v    = slash_q;
      pre      = mk_rec(KIND_DIV, sb, sbi, ln, 1'b0, 1'b0);
      main_v   = 1'b1;
      end_stmt = 1'b1;
      if (mode_q == MODE_COMMENT) begin
        main = mk_rec(KIND_COMMENT, sb, se, ln, 1'b0, 1'b1);
      end else if (mode_q == MODE_NORMAL) begin
        main = mk_rec(KIND_LITERAL, se, se, ln, 1'b0, 1'b1);
      end else begin
        main = mk_rec(KIND_LITERAL, sb, se, ln, 1'b0, 1'b1);
      end
    end else if (mode_q == MODE_STRING) begin
      stop_d = stop_inc;
      if (is_quote(c)) begin
        pre_v  = 1'b1;
        pre    = mk_rec(KIND_LITERAL, sb, se, ln, 1'b0, 1'b0);
        main_v = 1'b1;
        main   = mk_rec((c == CH_DQUOTE) ? KIND_DQUOTE : KIND_SQUOTE, se, sei, ln,
                        1'b0, 1'b0);
        mode_d = MODE_NORMAL;
      end else if (c == CH_CR) begin
        line_d = line_q + 1'b1;
        cr_d   = 1'b1;
      end else if ((c == CH_LF) && !cr_q) begin
        line_d = line_q + 1'b1;
      end
    end else if (mode_q == MODE_COMMENT) begin
      if ((c == CH_CR) || (c == CH_LF)) begin
        main_v   = 1'b1;
        main     = mk_rec(KIND_COMMENT, sb, se, ln, 1'b0, 1'b1);
        line_d   = line_q + 1'b1;
        end_stmt = 1'b1;
        cr_d     = (c == CH_CR);
      end else begin
        stop_d = stop_inc;
      end
    end else if (!has_handler(c)) begin
      main_v   = 1'b1;
      main     = mk_rec(KIND_LITERAL, se, sei, ln, 1'b1, 1'b1);
      end_stmt = 1'b1;
    end else if (slash_q && (c == CH_SLASH)) begin
      slash_d = 1'b0;
      mode_d  = MODE_COMMENT;
      stop_d  = stop_inc;
    end else begin
      if (slash_q) begin
        pre_v   = 1'b1;
        pre     = mk_rec(KIND_DIV, sb, sbi, ln, 1'b0, 1'b0);
        slash_d = 1'b0;
      end else if (flush) begin
        pre_v  = 1'b1;
        pre    = mk_rec(KIND_LITERAL, sb, se, ln, 1'b0, 1'b0);
        mode_d = MODE_NORMAL;
      end
      if ((c == CH_LF) && cr_q) begin
        // second half of CR LF: no effect
      end else if ((c == CH_CR) || (c == CH_LF)) begin
        line_d = line_q + 1'b1;
        cr_d   = (c == CH_CR);
      end else if (c == CH_SPACE) begin
        stop_d = stop_inc;
      end else if (is_alnum(c)) begin
        if (mode_q == MODE_NORMAL) begin
          mode_d  = MODE_LITERAL;
          start_d = stop_q;
        end
        stop_d = stop_inc;
      end else if (c == CH_SLASH) begin
        start_d = stop_q;
        stop_d  = stop_inc;
        slash_d = 1'b1;
      end else if (c == CH_SEMI) begin
        main_v   = 1'b1;
        main     = mk_rec(KIND_STMT_END, se, sei, ln, 1'b0, 1'b1);
        end_stmt = 1'b1;
      end else if (is_quote(c)) begin
        main_v  = 1'b1;
        main    = mk_rec((c == CH_DQUOTE) ? KIND_DQUOTE : KIND_SQUOTE, se, sei, ln,
                         1'b0, 1'b0);
        stop_d  = stop_inc;
        start_d = stop_inc;
        mode_d  = MODE_STRING;
      end else begin
        main_v = 1'b1;
        main   = mk_rec(op_kind(c), se, sei, ln, 1'b0, 1'b0);
        stop_d = stop_inc;
      end
    end

    if (end_stmt) begin
      mode_d  = MODE_NORMAL;
      slash_d = 1'b0;
      start_d = '0;
      stop_d  = '0;
    end
  end

  assign push_o        = accept && (pre_v || main_v);
  assign entry_o.two    = pre_v && main_v;
  assign entry_o.first  = pre_v ? pre : main;
  assign entry_o.second = main;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_NORMAL;
      slash_q <= 1'b0;
      cr_q    <= 1'b0;
      start_q <= '0;
      stop_q  <= '0;
      line_q  <= '0;
    end else if (accept) begin
      mode_q  <= mode_d;
      slash_q <= slash_d;
      cr_q    <= cr_d;
      start_q <= start_d;
      stop_q  <= stop_d;
      line_q  <= line_d;
    end
  end

endmodule

// File: rtl/slx_queue.sv
// ----------------------------------------------------------------------------
// slx_queue
// Small FIFO of result entries between the classifier and the serializer.
// ----------------------------------------------------------------------------
module slx_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  slx_pkg::entry_t entry_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            empty_o,
  output slx_pkg::entry_t head_o
);
  import slx_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  entry_t           mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [PTR_W:0]   cnt_q;

  assign full_o  = (cnt_q == (PTR_W+1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: rtl/slx_back.sv
// ----------------------------------------------------------------------------
// slx_back
// Serializer: sends the one or two records of the head entry, one per beat.
// ----------------------------------------------------------------------------
module slx_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  slx_pkg::entry_t head_i,
  output logic            pop_o,
  slx_out_if.source       out_o
);
  import slx_pkg::*;

  logic idx_q;
  logic last;
  rec_t rec;

  assign rec  = idx_q ? head_i.second : head_i.first;
  assign last = idx_q || !head_i.two;

  assign out_o.valid          = !empty_i;
  assign out_o.token_kind     = rec.kind;
  assign out_o.span_begin     = rec.span_begin;
  assign out_o.span_end       = rec.span_end;
  assign out_o.line_number    = rec.line;
  assign out_o.bad_char       = rec.bad;
  assign out_o.statement_done = rec.done;
  assign out_o.last_of_run    = last;

  assign pop_o = out_o.valid && out_o.ready && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 1'b0;
    end else if (out_o.valid && out_o.ready) begin
      idx_q <= !last;
    end
  end

endmodule

// File: rtl/slx_checker.sv
// ----------------------------------------------------------------------------
// slx_assert
// Port-level checks on the lexer result stream, bound to the top level.
// ----------------------------------------------------------------------------
module slx_assert (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [4:0] out_kind_i,
  input logic       out_bad_i,
  input logic       out_done_i,
  input logic       out_last_i
);
  import slx_pkg::*;

  // stalled beat keeps its kind, last and done flags
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_kind_i) &&
    $stable(out_last_i) && $stable(out_done_i))
    else $error("result changed while stalled");

  a_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_bad_i |-> out_done_i && out_last_i &&
    (out_kind_i == KIND_LITERAL))
    else $error("bad byte record malformed");

  a_done_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_done_i |-> (out_kind_i == KIND_LITERAL) ||
    (out_kind_i == KIND_COMMENT) || (out_kind_i == KIND_STMT_END))
    else $error("statement end on wrong kind");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_done_i |-> out_last_i)
    else $error("statement end not last of run");

endmodule

bind statement_lexer_core slx_assert u_slx_assert (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_kind_i  (out_o.token_kind),
  .out_bad_i   (out_o.bad_char),
  .out_done_i  (out_o.statement_done),
  .out_last_i  (out_o.last_of_run)
);

// File: tb/slx_checker.sv
// ----------------------------------------------------------------------------
// slx_checker
// Watches the byte and token channels of the statement lexer, models the
// lexer state beat by beat, and compares every token record in order.
// ----------------------------------------------------------------------------
module slx_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  slx_in_if           byte_mon,
  slx_out_if          tok_mon,
  output int unsigned pending_o,
  output int unsigned tokens_o,
  output int unsigned errors_o
);
  import slx_pkg::*;

  typedef enum logic [1:0] {
    LX_NORMAL  = 2'd0,
    LX_WORD    = 2'd1,
    LX_STRING  = 2'd2,
    LX_COMMENT = 2'd3
  } lex_mode_e;

  typedef struct packed {
    kind_e             kind;
    logic [SPAN_W-1:0] span_lo;
    logic [SPAN_W-1:0] span_hi;
    logic [LINE_W-1:0] line_no;
    logic              bad;
    logic              done;
    logic              last;
  } token_t;

  lex_mode_e         mode;
  logic              slash_wait;
  logic              after_cr;
  logic [SPAN_W-1:0] tok_lo;
  logic [SPAN_W-1:0] tok_hi;
  logic [LINE_W-1:0] line_cnt;

  token_t      token_q[$];
  token_t      held;
  logic        have_held;
  token_t      want;
  int unsigned err_cnt;
  int unsigned tok_cnt;

  function automatic logic [SPAN_W-1:0] bump(input logic [SPAN_W-1:0] x);
    return (x == '1) ? x : x + 1'b1;
  endfunction

  function automatic logic word_char(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9");
  endfunction

  function automatic logic op_lookup(input logic [7:0] c, output kind_e k);
    op_lookup = 1'b1;
    k = KIND_LITERAL;
    case (c)
      CH_COMMA:  k = KIND_COMMA;
      CH_EQUALS: k = KIND_EQUALS;
      CH_PLUS:   k = KIND_ADD;
      CH_MINUS:  k = KIND_SUB;
      CH_STAR:   k = KIND_MUL;
      CH_LPAREN: k = KIND_LPAREN;
      CH_RPAREN: k = KIND_RPAREN;
      CH_LBRACE: k = KIND_LBRACE;
      CH_RBRACE: k = KIND_RBRACE;
      CH_LBRACK: k = KIND_LBRACK;
      CH_RBRACK: k = KIND_RBRACK;
      default:   op_lookup = 1'b0;
    endcase
  endfunction

  function automatic void emit(input kind_e k, input logic [SPAN_W-1:0] lo,
                               input logic [SPAN_W-1:0] hi, input logic bad,
                               input logic done);
    if (have_held) begin
      token_q = {token_q, held};
    end
    held.kind    = k;
    held.span_lo = lo;
    held.span_hi = hi;
    held.line_no = line_cnt;
    held.bad     = bad;
    held.done    = done;
    held.last    = 1'b0;
    have_held    = 1'b1;
  endfunction

  function automatic void close_stmt();
    mode       = LX_NORMAL;
    slash_wait = 1'b0;
    tok_lo     = '0;
    tok_hi     = '0;
  endfunction

  function automatic void flush_word();
    if (mode == LX_WORD) begin
      emit(KIND_LITERAL, tok_lo, tok_hi, 1'b0, 1'b0);
      mode = LX_NORMAL;
    end
  endfunction

  function automatic kind_e quote_kind(input logic [7:0] c);
    return (c == CH_DQUOTE) ? KIND_DQUOTE : KIND_SQUOTE;
  endfunction

  function automatic void lex_beat(input logic [7:0] c, input logic eoi);
    logic  was_cr;
    logic  is_op;
    logic  is_quote;
    logic  is_brk;
    logic  known;
    kind_e op_k;
    was_cr    = after_cr;
    after_cr  = 1'b0;
    have_held = 1'b0;
    is_op     = op_lookup(c, op_k);
    is_quote  = (c == CH_DQUOTE) || (c == CH_SQUOTE);
    is_brk    = (c == CH_CR) || (c == CH_LF);
    known     = word_char(c) || is_quote || is_op || is_brk || (c == CH_SPACE) ||
                (c == CH_SLASH) || (c == CH_SEMI);
    if (eoi) begin
      if (slash_wait) begin
        emit(KIND_DIV, tok_lo, bump(tok_lo), 1'b0, 1'b0);
      end
      if (mode == LX_COMMENT) begin
        emit(KIND_COMMENT, tok_lo, tok_hi, 1'b0, 1'b1);
      end else if (mode == LX_NORMAL) begin
        emit(KIND_LITERAL, tok_hi, tok_hi, 1'b0, 1'b1);
      end else begin
        emit(KIND_LITERAL, tok_lo, tok_hi, 1'b0, 1'b1);
      end
      close_stmt();
    end else if (mode == LX_STRING) begin
      if (is_quote) begin
        emit(KIND_LITERAL, tok_lo, tok_hi, 1'b0, 1'b0);
        emit(quote_kind(c), tok_hi, bump(tok_hi), 1'b0, 1'b0);
        tok_hi = bump(tok_hi);
        mode   = LX_NORMAL;
      end else begin
        tok_hi = bump(tok_hi);
        if (c == CH_CR) begin
          line_cnt = line_cnt + 1'b1;
          after_cr = 1'b1;
        end else if (c == CH_LF && !was_cr) begin
          line_cnt = line_cnt + 1'b1;
        end
      end
    end else if (mode == LX_COMMENT) begin
      if (is_brk) begin
        emit(KIND_COMMENT, tok_lo, tok_hi, 1'b0, 1'b1);
        line_cnt = line_cnt + 1'b1;
        close_stmt();
        after_cr = (c == CH_CR);
      end else begin
        tok_hi = bump(tok_hi);
      end
    end else if (!known) begin
      emit(KIND_LITERAL, tok_hi, bump(tok_hi), 1'b1, 1'b1);
      close_stmt();
    end else if (slash_wait && c == CH_SLASH) begin
      slash_wait = 1'b0;
      mode       = LX_COMMENT;
      tok_hi     = bump(tok_hi);
    end else begin
      if (slash_wait) begin
        emit(KIND_DIV, tok_lo, bump(tok_lo), 1'b0, 1'b0);
        slash_wait = 1'b0;
      end
      if (c == CH_LF && was_cr) begin
        // tail of CRLF, swallowed
      end else if (is_brk) begin
        flush_word();
        line_cnt = line_cnt + 1'b1;
        after_cr = (c == CH_CR);
      end else if (c == CH_SPACE) begin
        flush_word();
        tok_hi = bump(tok_hi);
      end else if (word_char(c)) begin
        if (mode == LX_NORMAL) begin
          mode   = LX_WORD;
          tok_lo = tok_hi;
        end
        tok_hi = bump(tok_hi);
      end else if (c == CH_SLASH) begin
        flush_word();
        tok_lo     = tok_hi;
        tok_hi     = bump(tok_hi);
        slash_wait = 1'b1;
      end else if (c == CH_SEMI) begin
        flush_word();
        emit(KIND_STMT_END, tok_hi, bump(tok_hi), 1'b0, 1'b1);
        close_stmt();
      end else if (is_quote) begin
        flush_word();
        emit(quote_kind(c), tok_hi, bump(tok_hi), 1'b0, 1'b0);
        tok_hi = bump(tok_hi);
        mode   = LX_STRING;
        tok_lo = tok_hi;
      end else begin
        flush_word();
        emit(op_k, tok_hi, bump(tok_hi), 1'b0, 1'b0);
        tok_hi = bump(tok_hi);
      end
    end
    if (have_held) begin
      held.last = 1'b1;
      token_q   = {token_q, held};
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      err_cnt++;
      $display("%0t: %s mismatch on token beat %0d, expected %0d, actual %0d",
               $time, name, tok_cnt, exp_v, act_v);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      close_stmt();
      after_cr  = 1'b0;
      line_cnt  = '0;
      have_held = 1'b0;
      token_q.delete();
      err_cnt   = 0;
      tok_cnt   = 0;
    end else begin
      if (byte_mon.valid && byte_mon.ready) begin
        lex_beat(byte_mon.char_code, byte_mon.end_of_input);
      end
      if (tok_mon.valid && tok_mon.ready) begin
        if (token_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected token beat, expected none, actual kind %0d [%0d,%0d)",
                   $time, tok_mon.token_kind, tok_mon.span_begin, tok_mon.span_end);
        end else begin
          want = token_q.pop_front();
          check_field("token_kind", 32'(want.kind), 32'(tok_mon.token_kind));
          check_field("span_begin", 32'(want.span_lo), 32'(tok_mon.span_begin));
          check_field("span_end", 32'(want.span_hi), 32'(tok_mon.span_end));
          check_field("line_number", 32'(want.line_no), 32'(tok_mon.line_number));
          check_field("bad_char", 32'(want.bad), 32'(tok_mon.bad_char));
          check_field("statement_done", 32'(want.done), 32'(tok_mon.statement_done));
          check_field("last_of_run", 32'(want.last), 32'(tok_mon.last_of_run));
        end
        tok_cnt++;
      end
    end
    pending_o <= token_q.size();
    tokens_o  <= tok_cnt;
    errors_o  <= err_cnt;
  end

endmodule

// File: tb/tb_statement_lexer_core.sv
// ----------------------------------------------------------------------------
// tb_statement_lexer_core
// Drives source bytes into the statement lexer: directed corner cases with
// output idling, then random statements with idling on both channels, a long
// output stall and a final stretch without idling. Checking is by slx_checker.
// ----------------------------------------------------------------------------
module tb_statement_lexer_core;
  import slx_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned RANDOM_BYTES = 860;
  localparam int unsigned CALM_BYTES = 150;
  localparam int unsigned HOLD_CYCLES = 300;

  logic clk_i = 1'b0;
  logic rst_ni;

  slx_in_if  byte_if ();
  slx_out_if tok_if ();

  int unsigned pending;
  int unsigned tokens;
  int unsigned errors;
  int unsigned n_bytes = 0;
  int unsigned cycle_cnt;
  bit          src_idle = 1'b0;
  bit          snk_idle = 1'b1;
  bit          hold_go = 1'b0;
  bit          hold_done = 1'b0;

  always #6 clk_i = ~clk_i;

  statement_lexer_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_if),
    .out_o  (tok_if)
  );

  slx_checker i_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_mon  (byte_if),
    .tok_mon   (tok_if),
    .pending_o (pending),
    .tokens_o  (tokens),
    .errors_o  (errors)
  );

  task automatic send_beat(input logic [7:0] c, input logic eoi);
    byte_if.valid        <= 1'b1;
    byte_if.char_code    <= c;
    byte_if.end_of_input <= eoi;
    @(posedge clk_i);
    while (!byte_if.ready) @(posedge clk_i);
    n_bytes++;
    if (src_idle && $urandom_range(0, 5) == 0) begin
      byte_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_beat(s[i], 1'b0);
    end
  endtask

  function automatic logic [7:0] pick_alnum();
    int unsigned r;
    r = $urandom_range(0, 61);
    if (r < 10) return 8'("0" + r);
    if (r < 36) return 8'("A" + r - 10);
    return 8'("a" + r - 36);
  endfunction

  function automatic logic [7:0] pick_op();
    logic [7:0] c;
    case ($urandom_range(0, 10))
      0:       c = CH_COMMA;
      1:       c = CH_EQUALS;
      2:       c = CH_PLUS;
      3:       c = CH_MINUS;
      4:       c = CH_STAR;
      5:       c = CH_LPAREN;
      6:       c = CH_RPAREN;
      7:       c = CH_LBRACE;
      8:       c = CH_RBRACE;
      9:       c = CH_LBRACK;
      default: c = CH_RBRACK;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] pick_bad();
    string      punct;
    logic [7:0] c;
    punct = "!#$%&.:<>?@\\^_|~";
    case ($urandom_range(0, 3))
      0:       c = 8'($urandom_range(8'h00, 8'h09));
      1:       c = 8'($urandom_range(8'h80, 8'hFF));
      2:       c = 8'($urandom_range(8'h0E, 8'h1F));
      default: c = punct[$urandom_range(0, punct.len() - 1)];
    endcase
    return c;
  endfunction

  // string body byte: anything but a quote
  function automatic logic [7:0] pick_body();
    logic [7:0] c;
    do c = 8'($urandom); while (c == CH_DQUOTE || c == CH_SQUOTE);
    return c;
  endfunction

  // comment body byte: anything but a line break
  function automatic logic [7:0] pick_remark();
    logic [7:0] c;
    do c = 8'($urandom); while (c == CH_CR || c == CH_LF);
    return c;
  endfunction

  function automatic logic [7:0] pick_quote();
    return $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
  endfunction

  task automatic send_break();
    case ($urandom_range(0, 2))
      0:       send_beat(CH_CR, 1'b0);
      1:       send_beat(CH_LF, 1'b0);
      default: begin
        send_beat(CH_CR, 1'b0);
        send_beat(CH_LF, 1'b0);
      end
    endcase
  endtask

  task automatic random_statement();
    int unsigned pieces;
    pieces = $urandom_range(1, 6);
    repeat (pieces) begin
      case ($urandom_range(0, 10))
        0, 1: begin
          repeat ($urandom_range(1, 6)) send_beat(pick_alnum(), 1'b0);
        end
        2, 3: send_beat(pick_op(), 1'b0);
        4:    send_beat(CH_SPACE, 1'b0);
        5: begin
          send_beat(pick_quote(), 1'b0);
          repeat ($urandom_range(0, 8)) send_beat(pick_body(), 1'b0);
          send_beat(pick_quote(), 1'b0);
        end
        6:    send_beat(CH_SLASH, 1'b0);
        7:    send_break();
        8: begin
          send_text("//");
          repeat ($urandom_range(0, 8)) send_beat(pick_remark(), 1'b0);
          send_break();
        end
        9:    send_beat(8'($urandom), $urandom_range(0, 15) == 0);
        default: begin
          repeat ($urandom_range(1, 4)) send_beat(pick_alnum(), 1'b0);
          send_beat(CH_SPACE, 1'b0);
        end
      endcase
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: send_beat(CH_SEMI, 1'b0);
      6:                send_beat(8'($urandom), 1'b1);
      7:                send_beat(pick_bad(), 1'b0);
      default:          ;
    endcase
  endtask

  initial begin
    tok_if.ready <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_go && !hold_done) begin
        tok_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end else if (snk_idle && $urandom_range(0, 3) == 0) begin
        tok_if.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end else begin
        tok_if.ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("statement_lexer_core test failed");
    $finish;
  end

  initial begin
    int unsigned rand_start;
    rst_ni = 1'b0;
    byte_if.valid        <= 1'b0;
    byte_if.char_code    <= '0;
    byte_if.end_of_input <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners
    send_text("A9/z*\"");
    send_beat(8'hFF, 1'b0);
    send_beat(CH_CR, 1'b0);
    send_beat(CH_LF, 1'b0);
    send_text("'//x");
    send_beat(CH_CR, 1'b0);
    send_beat(CH_LF, 1'b0);
    send_beat(8'h09, 1'b0);
    send_text(";/");
    send_beat(8'h00, 1'b1);
    send_beat(8'h00, 1'b0);
    send_text("\"q");
    send_beat(8'hFF, 1'b1);
    send_text("//");
    send_beat(8'h55, 1'b1);

    src_idle   = 1'b1;
    hold_go    = 1'b1;
    rand_start = n_bytes;
    while (n_bytes - rand_start < RANDOM_BYTES) begin
      if (n_bytes - rand_start >= RANDOM_BYTES - CALM_BYTES) begin
        src_idle = 1'b0;
        snk_idle = 1'b0;
      end
      random_statement();
    end
    byte_if.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Lexed %0d bytes (%0d random), checked %0d token beats.",
             n_bytes, n_bytes - rand_start, tokens);
    $display("Run included strings, comments, bad bytes, line breaks and a long output stall.");
    if (errors == 0 && pending == 0) begin
      $display("statement_lexer_core test passed");
    end else begin
      $display("statement_lexer_core test failed");
    end
    $finish;
  end

endmodule
